// File: hdl/mi4_pkg.sv
package mi4_pkg;

  // Source of the wide multiplier operand.
  typedef enum logic [1:0] {
    SRC_ELEM  = 2'd0,
    SRC_MINOR = 2'd1,
    SRC_ADJ   = 2'd2
  } a_src_t;

  // Row pairs and column pairs of the shared 2x2 minors.
  localparam logic [1:0] PAIR_ROW_A [6] = '{2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] PAIR_ROW_B [6] = '{2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1};
  localparam logic [1:0] PAIR_COL_A [3] = '{2'd2, 2'd1, 2'd1};
  localparam logic [1:0] PAIR_COL_B [3] = '{2'd3, 2'd3, 2'd2};

  // Cofactor expansion: minor pair and element row of each of the three terms.
  localparam logic [2:0] TERM_PAIR [4][3] = '{
    '{3'd0, 3'd1, 3'd2}, '{3'd0, 3'd3, 3'd4}, '{3'd1, 3'd3, 3'd5}, '{3'd2, 3'd4, 3'd5}
  };
  localparam logic [1:0] TERM_ROW [4][3] = '{
    '{2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3}, '{2'd0, 2'd1, 2'd2}
  };

  typedef struct packed {
    logic       col_wr;
    logic       mac_start;
    logic       mac_clear;
    logic       mac_step;
    logic       mac_sub;
    a_src_t     a_src;
    logic [1:0] a_col;
    logic [1:0] a_row;
    logic [1:0] e_col;
    logic [1:0] e_row;
    logic [4:0] minor_idx;
    logic [3:0] adj_idx;
    logic       store_minor;
    logic       store_adj;
    logic       store_det;
    logic [4:0] store_idx;
    logic       div_load;
    logic       div_bias;
    logic       div_step;
    logic       div_done;
    logic [1:0] res_idx;
  } cmd_t;

  typedef struct packed {
    logic step_last;
  } status_t;

endpackage

// File: hdl/matrix_inverse_4x4.sv
// Columns 0..2 are stored as they are accepted; the block is ready again next cycle.
// Column 3 runs 88 products on one shift-add, one-bit-a-cycle multiplier, 35 stores,
// 16 restoring divisions and four result columns, each held on the outputs until taken;
// no new column is accepted until the last result column has been taken.
// Reset (rst, synchronous, active high) idles the sequencer.
module matrix_inverse_4x4 #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   col_index,
  input  logic signed [WORD_WIDTH-1:0] elem_x,
  input  logic signed [WORD_WIDTH-1:0] elem_y,
  input  logic signed [WORD_WIDTH-1:0] elem_z,
  input  logic signed [WORD_WIDTH-1:0] elem_w,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_col,
  output logic signed [WORD_WIDTH-1:0] res_x,
  output logic signed [WORD_WIDTH-1:0] res_y,
  output logic signed [WORD_WIDTH-1:0] res_z,
  output logic signed [WORD_WIDTH-1:0] res_w,
  output logic                         singular,
  output logic                         last_col
);

  // Sequencer walks minors, adjugate, determinant, then divides entry by entry;
  // the datapath holds the stores, the multiply accumulator and the divider.
  // The matrix store keeps its contents across reset and holds no defined value
  // until written.
  mi4_pkg::cmd_t    cmd;
  mi4_pkg::status_t status;

  mi4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .col_index (col_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_col   (out_col),
    .last_col  (last_col),
    .cmd       (cmd),
    .status    (status)
  );

  // Result words are held in the datapath output registers until taken.
  mi4_datapath #(
    .W (WORD_WIDTH),
    .F (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .col_index (col_index),
    .elem_x    (elem_x),
    .elem_y    (elem_y),
    .elem_z    (elem_z),
    .elem_w    (elem_w),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .res_w     (res_w),
    .singular  (singular)
  );

endmodule

// File: hdl/mi4_datapath.sv
module mi4_datapath #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  mi4_pkg::cmd_t       cmd,
  output mi4_pkg::status_t    status,
  input  logic [1:0]          col_index,
  input  logic signed [W-1:0] elem_x,
  input  logic signed [W-1:0] elem_y,
  input  logic signed [W-1:0] elem_z,
  input  logic signed [W-1:0] elem_w,
  output logic signed [W-1:0] res_x,
  output logic signed [W-1:0] res_y,
  output logic signed [W-1:0] res_z,
  output logic signed [W-1:0] res_w,
  output logic                singular
);

  localparam int MW   = 2 * W + 1;
  localparam int AW   = 3 * W + 3;
  localparam int ACCW = 4 * W + 5;
  localparam int CW   = $clog2(W);
  localparam int ROFF = 2 * F + 1;
  localparam int DV_A = 3 * W + 3 + 2 * F;
  localparam int DV_B = 5 * W + 4;
  localparam int DVW  = ((DV_A > DV_B) ? DV_A : DV_B) + 1;

  // Column store, one row per matrix column.
  logic [4*W-1:0] mat [4];
  logic [4*W-1:0] a_col_q;
  logic [4*W-1:0] e_col_q;
  logic [MW-1:0]  minor_mem [18];
  logic [MW-1:0]  minor_q;
  logic [AW-1:0]  adj_mem [16];
  logic [AW-1:0]  adj_q;

  logic [ACCW-1:0] acc;
  logic [ACCW-1:0] acc_next;
  logic [ACCW-1:0] ash;
  logic [ACCW-1:0] a_ext;
  logic [W-1:0]    ebits;
  logic [W-1:0]    a_elem;
  logic [W-1:0]    e_word;
  logic [CW-1:0]   bit_cnt;
  logic            step_last;
  logic            sub_eff;

  logic [ACCW-1:0] det_abs;
  logic            det_neg;
  logic [AW-1:0]   adj_abs;
  logic [DVW-1:0]  rem;
  logic [DVW-1:0]  dsh;
  logic            rem_ge;
  logic [W-1:0]    quo;
  logic            neg;
  logic [W-1:0]    res_val;
  logic [W-1:0]    res [4];

  always_ff @(posedge clk) begin
    if (cmd.col_wr) begin
      mat[col_index] <= {elem_w, elem_z, elem_y, elem_x};
    end
    a_col_q <= mat[cmd.a_col];
    e_col_q <= mat[cmd.e_col];
  end

  always_ff @(posedge clk) begin
    if (cmd.store_minor) begin
      minor_mem[cmd.store_idx] <= acc[MW-1:0];
    end
    minor_q <= minor_mem[cmd.minor_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.store_adj) begin
      adj_mem[cmd.store_idx[3:0]] <= acc[AW-1:0];
    end
    adj_q <= adj_mem[cmd.adj_idx];
  end

  assign a_elem = a_col_q[cmd.a_row*W +: W];
  assign e_word = e_col_q[cmd.e_row*W +: W];

  always_comb begin
    case (cmd.a_src)
      mi4_pkg::SRC_ELEM:  a_ext = {{(ACCW-W){a_elem[W-1]}}, a_elem};
      mi4_pkg::SRC_MINOR: a_ext = {{(ACCW-MW){minor_q[MW-1]}}, minor_q};
      mi4_pkg::SRC_ADJ:   a_ext = {{(ACCW-AW){adj_q[AW-1]}}, adj_q};
      default:            a_ext = '0;
    endcase
  end

  // Shift-add multiply; the top multiplier bit carries negative weight.
  assign step_last = (bit_cnt == CW'(W - 1));
  assign sub_eff   = cmd.mac_sub ^ step_last;

  always_comb begin
    acc_next = acc;
    if (ebits[0]) begin
      acc_next = sub_eff ? (acc - ash) : (acc + ash);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      ash   <= a_ext;
      ebits <= e_word;
      if (cmd.mac_clear) begin
        acc <= '0;
      end
    end else if (cmd.mac_step) begin
      acc   <= acc_next;
      ash   <= ash << 1;
      ebits <= ebits >> 1;
    end
    if (cmd.mac_start || cmd.div_bias) begin
      bit_cnt <= '0;
    end else if (cmd.mac_step || cmd.div_step) begin
      bit_cnt <= bit_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_det) begin
      det_abs  <= acc[ACCW-1] ? (~acc + ACCW'(1)) : acc;
      det_neg  <= acc[ACCW-1];
      singular <= (acc == '0);
    end
  end

  // Restoring division; a set top quotient bit means the result saturates.
  assign adj_abs = adj_q[AW-1] ? (~adj_q + AW'(1)) : adj_q;
  assign rem_ge  = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= DVW'(adj_abs) << ROFF;
      neg <= adj_q[AW-1] ^ det_neg;
    end else if (cmd.div_bias) begin
      rem <= rem + DVW'(det_abs);
      dsh <= DVW'(det_abs) << W;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[W-2:0], rem_ge};
      dsh <= dsh >> 1;
    end
  end

  always_comb begin
    if (singular) begin
      res_val = '0;
    end else if (quo[W-1]) begin
      res_val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res_val = neg ? (~quo + W'(1)) : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_done) begin
      res[cmd.res_idx] <= res_val;
    end
  end

  assign res_x = res[0];
  assign res_y = res[1];
  assign res_z = res[2];
  assign res_w = res[3];

  assign status.step_last = step_last;

endmodule

// File: hdl/mi4_ctrl.sv
module mi4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        col_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_col,
  output logic              last_col,
  output mi4_pkg::cmd_t     cmd,
  input  mi4_pkg::status_t  status
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_MAC_FETCH = 11'b00000000010,
    ST_MAC_START = 11'b00000000100,
    ST_MAC_RUN   = 11'b00000001000,
    ST_STORE     = 11'b00000010000,
    ST_DIV_FETCH = 11'b00000100000,
    ST_DIV_LOAD  = 11'b00001000000,
    ST_DIV_BIAS  = 11'b00010000000,
    ST_DIV_RUN   = 11'b00100000000,
    ST_DIV_DONE  = 11'b01000000000,
    ST_EMIT      = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_MINOR = 3'b001,
    PH_ADJ   = 3'b010,
    PH_DET   = 3'b100
  } phase_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [2:0] cnt_a, cnt_a_next;
  logic [1:0] cnt_b, cnt_b_next;
  logic [1:0] term, term_next;
  logic       accept;
  logic       last_term;
  logic [1:0] fq;
  logic [2:0] pidx;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_EMIT);
  assign out_col   = cnt_a[1:0];
  assign last_col  = (cnt_a[1:0] == 2'd3);

  always_comb begin
    case (phase)
      PH_MINOR: last_term = (term == 2'd1);
      PH_ADJ:   last_term = (term == 2'd2);
      PH_DET:   last_term = (term == 2'd3);
      default:  last_term = 1'b1;
    endcase
  end

  assign fq   = (cnt_b < 2'd2) ? 2'd0 : (cnt_b - 2'd1);
  assign pidx = mi4_pkg::TERM_PAIR[cnt_a[1:0]][term];

  // Operand addresses follow the counters and hold across fetch and start.
  always_comb begin
    cmd = '0;
    cmd.col_wr  = accept;
    cmd.res_idx = cnt_b;
    cmd.adj_idx = (phase == PH_DET) ? {term, 2'b00} : {cnt_a[1:0], cnt_b};
    case (phase)
      PH_MINOR: begin
        cmd.a_src     = mi4_pkg::SRC_ELEM;
        cmd.a_row     = mi4_pkg::PAIR_ROW_A[cnt_a];
        cmd.e_row     = mi4_pkg::PAIR_ROW_B[cnt_a];
        cmd.a_col     = term[0] ? mi4_pkg::PAIR_COL_B[cnt_b] : mi4_pkg::PAIR_COL_A[cnt_b];
        cmd.e_col     = term[0] ? mi4_pkg::PAIR_COL_A[cnt_b] : mi4_pkg::PAIR_COL_B[cnt_b];
        cmd.mac_sub   = term[0];
        cmd.store_idx = 5'({cnt_a, 1'b0}) + 5'(cnt_a) + 5'(cnt_b);
      end
      PH_ADJ: begin
        cmd.a_src     = mi4_pkg::SRC_MINOR;
        cmd.minor_idx = 5'({pidx, 1'b0}) + 5'(pidx) + 5'(fq);
        cmd.e_col     = (cnt_b == 2'd0) ? 2'd1 : 2'd0;
        cmd.e_row     = mi4_pkg::TERM_ROW[cnt_a[1:0]][term];
        cmd.mac_sub   = (term == 2'd1) ^ cnt_b[0] ^ cnt_a[0];
        cmd.store_idx = {1'b0, cnt_a[1:0], cnt_b};
      end
      PH_DET: begin
        cmd.a_src = mi4_pkg::SRC_ADJ;
        cmd.e_col = 2'd0;
        cmd.e_row = term;
      end
      default: begin
        cmd.a_src = mi4_pkg::SRC_ELEM;
      end
    endcase
    case (state)
      ST_MAC_START: begin
        cmd.mac_start = 1'b1;
        cmd.mac_clear = (term == 2'd0);
      end
      ST_MAC_RUN:  cmd.mac_step = 1'b1;
      ST_STORE: begin
        cmd.store_minor = (phase == PH_MINOR);
        cmd.store_adj   = (phase == PH_ADJ);
        cmd.store_det   = (phase == PH_DET);
      end
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV_BIAS: cmd.div_bias = 1'b1;
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      ST_DIV_DONE: cmd.div_done = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_a_next = cnt_a;
    cnt_b_next = cnt_b;
    term_next  = term;
    case (state)
      ST_IDLE: begin
        if (accept && (col_index == 2'd3)) begin
          phase_next = PH_MINOR;
          cnt_a_next = '0;
          cnt_b_next = '0;
          term_next  = '0;
          state_next = ST_MAC_FETCH;
        end
      end
      ST_MAC_FETCH: state_next = ST_MAC_START;
      ST_MAC_START: state_next = ST_MAC_RUN;
      ST_MAC_RUN: begin
        if (status.step_last) begin
          if (last_term) begin
            state_next = ST_STORE;
          end else begin
            term_next  = term + 2'd1;
            state_next = ST_MAC_FETCH;
          end
        end
      end
      ST_STORE: begin
        term_next  = '0;
        state_next = ST_MAC_FETCH;
        case (phase)
          PH_MINOR: begin
            if (cnt_b == 2'd2) begin
              cnt_b_next = '0;
              if (cnt_a == 3'd5) begin
                cnt_a_next = '0;
                phase_next = PH_ADJ;
              end else begin
                cnt_a_next = cnt_a + 3'd1;
              end
            end else begin
              cnt_b_next = cnt_b + 2'd1;
            end
          end
          PH_ADJ: begin
            if (cnt_b == 2'd3) begin
              cnt_b_next = '0;
              if (cnt_a == 3'd3) begin
                cnt_a_next = '0;
                phase_next = PH_DET;
              end else begin
                cnt_a_next = cnt_a + 3'd1;
              end
            end else begin
              cnt_b_next = cnt_b + 2'd1;
            end
          end
          default: begin
            phase_next = PH_MINOR;
            cnt_a_next = '0;
            cnt_b_next = '0;
            state_next = ST_DIV_FETCH;
          end
        endcase
      end
      ST_DIV_FETCH: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_next = ST_DIV_BIAS;
      ST_DIV_BIAS:  state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (status.step_last) begin
          state_next = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        if (cnt_b == 2'd3) begin
          state_next = ST_EMIT;
        end else begin
          cnt_b_next = cnt_b + 2'd1;
          state_next = ST_DIV_FETCH;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cnt_b_next = '0;
          if (cnt_a[1:0] == 2'd3) begin
            cnt_a_next = '0;
            state_next = ST_IDLE;
          end else begin
            cnt_a_next = cnt_a + 3'd1;
            state_next = ST_DIV_FETCH;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_MINOR;
      cnt_a <= '0;
      cnt_b <= '0;
      term  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt_a <= cnt_a_next;
      cnt_b <= cnt_b_next;
      term  <= term_next;
    end
  end

endmodule
